>>> sv/env_sensor_compensation_assert.svh
// Assertion macros for the checker file of the sensor compensation block
`ifndef ENV_SENSOR_COMPENSATION_ASSERT_SVH
`define ENV_SENSOR_COMPENSATION_ASSERT_SVH

// check under reset qualification
`define ESC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check that also covers the reset cycles
`define ESC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/esc_pkg.sv
// Types, constants and arithmetic helpers of the sensor compensation block
package esc_pkg;

    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TEMP_CALIB = 3'd0,
        REG_PRESS_A    = 3'd1,
        REG_PRESS_B    = 3'd2,
        REG_PRESS_C    = 3'd3,
        REG_HUM        = 3'd4,
        REG_HUM_H6     = 3'd5
    } t_reg_idx;

    localparam logic [63:0] P_FINE_OFS  = 64'd128000;
    localparam logic [20:0] P_ADC_BASE  = 21'd1048576;
    localparam logic [63:0] P_SCALE     = 64'd3125;
    localparam logic [63:0] P_HALF      = 64'h0000_8000_0000_0000;
    localparam logic [31:0] H_FINE_OFS  = 32'd76800;
    localparam logic [31:0] H_ROUND     = 32'd16384;
    localparam logic [31:0] H_BIAS_A    = 32'd32768;
    localparam logic [31:0] H_BIAS_B    = 32'd2097152;
    localparam logic [31:0] H_BIAS_C    = 32'd8192;
    localparam logic [31:0] H_MAX       = 32'd419430400;
    localparam logic [31:0] T_ROUND     = 32'd128;

    typedef struct packed {
        logic [47:0] temp;
        logic [63:0] pa;
        logic [63:0] pb;
        logic [15:0] pc;
        logic [63:0] hum;
        logic [7:0]  h6;
    } t_calib;

    typedef struct packed {
        logic [19:0] adc_temp;
        logic [19:0] adc_press;
        logic [15:0] adc_hum;
    } t_sample;

    typedef struct packed {
        logic signed [15:0] temp_centi;
        logic [31:0]        press_q24_8;
        logic               press_invalid;
        logic [16:0]        hum_q22_10;
    } t_result;

    typedef struct packed {
        t_sample     smp;
        logic [31:0] fine;
        logic [15:0] temp_centi;
        logic [16:0] hum;
        logic [63:0] num;
        logic [30:0] den;
        logic [63:0] quo;
        logic        neg;
        logic        dz;
        logic [31:0] press;
        logic        press_invalid;
    } t_item;

    typedef struct packed {
        logic [63:0] ll;
        logic [31:0] lh;
        logic [31:0] hl;
    } t_pp;

    function automatic logic [31:0] sx16_32(input logic [15:0] x);
        return {{16{x[15]}}, x};
    endfunction

    function automatic logic [63:0] sx16_64(input logic [15:0] x);
        return {{48{x[15]}}, x};
    endfunction

    function automatic logic [31:0] sx8_32(input logic [7:0] x);
        return {{24{x[7]}}, x};
    endfunction

    function automatic logic [31:0] asr32(input logic [31:0] x, input int unsigned s);
        return 32'($signed(x) >>> s);
    endfunction

    function automatic logic [63:0] asr64(input logic [63:0] x, input int unsigned s);
        return 64'($signed(x) >>> s);
    endfunction

    // partial products of a 64 x 64 product taken modulo 2^64
    function automatic t_pp mul_pp(input logic [63:0] a, input logic [63:0] b);
        t_pp p;
        p.ll = a[31:0] * b[31:0];
        p.lh = a[31:0] * b[63:32];
        p.hl = a[63:32] * b[31:0];
        return p;
    endfunction

    function automatic logic [63:0] mul_sum(input t_pp p);
        return p.ll + {p.lh + p.hl, 32'h0};
    endfunction

endpackage

>>> sv/esc_stream_if.sv
// Valid/ready stream channel with a typed payload
interface esc_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> sv/esc_temp.sv
// Fine temperature and temperature output stages
module esc_temp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  esc_pkg::t_item i_item,
    input  esc_pkg::t_calib i_cal,
    output logic           o_valid,
    output esc_pkg::t_item o_item
);
    import esc_pkg::*;

    localparam int N = 5;

    typedef struct packed {
        t_item       item;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] ma;
        logic [31:0] mb;
        logic [31:0] v1;
        logic [31:0] m3;
    } t_st;

    t_st          r_st [N];
    t_st          n_st [N];
    logic [N-1:0] r_vld;

    always_comb begin
        logic [31:0] tc;
        logic [15:0] t1;
        t1 = i_cal.temp[15:0];
        n_st[0]      = '0;
        n_st[0].item = i_item;
        n_st[0].a    = {15'b0, i_item.smp.adc_temp[19:3]} - {15'b0, t1, 1'b0};
        n_st[0].b    = {16'b0, i_item.smp.adc_temp[19:4]} - {16'b0, t1};

        n_st[1]    = r_st[0];
        n_st[1].ma = r_st[0].a * sx16_32(i_cal.temp[31:16]);
        n_st[1].mb = r_st[0].b * r_st[0].b;

        n_st[2]    = r_st[1];
        n_st[2].v1 = asr32(r_st[1].ma, 11);
        n_st[2].m3 = asr32(r_st[1].mb, 12) * sx16_32(i_cal.temp[47:32]);

        n_st[3]           = r_st[2];
        n_st[3].item.fine = r_st[2].v1 + asr32(r_st[2].m3, 14);

        n_st[4] = r_st[3];
        tc = asr32({r_st[3].item.fine[29:0], 2'b0} + r_st[3].item.fine + T_ROUND, 8);
        if ($signed(tc) < -32'sd32768) begin
            n_st[4].item.temp_centi = 16'h8000;
        end else if ($signed(tc) > 32'sd32767) begin
            n_st[4].item.temp_centi = 16'h7fff;
        end else begin
            n_st[4].item.temp_centi = tc[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[N-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st <= n_st;
        end
    end

    assign o_valid = r_vld[N-1];
    assign o_item  = r_st[N-1].item;
endmodule

>>> sv/esc_hum.sv
// Humidity compensation stages
module esc_hum (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  esc_pkg::t_item  i_item,
    input  esc_pkg::t_calib i_cal,
    output logic            o_valid,
    output esc_pkg::t_item  o_item
);
    import esc_pkg::*;

    localparam int N = 10;

    typedef struct packed {
        t_item       item;
        logic [31:0] x;
        logic [31:0] mh5;
        logic [31:0] mh6;
        logic [31:0] mh3;
        logic [31:0] ra;
        logic [31:0] p1;
        logic [31:0] p2;
        logic [31:0] bm;
        logic [31:0] b2;
        logic [31:0] c;
        logic [31:0] bm3;
        logic [31:0] v;
        logic [31:0] ss;
        logic [31:0] t;
    } t_st;

    t_st          r_st [N];
    t_st          n_st [N];
    logic [N-1:0] r_vld;

    always_comb begin
        logic [31:0] sa;
        logic [31:0] sv;
        logic [31:0] vv;
        logic [31:0] vc;
        n_st[0]      = '0;
        n_st[0].item = i_item;
        n_st[0].x    = i_item.fine - H_FINE_OFS;

        n_st[1]     = r_st[0];
        n_st[1].mh5 = sx16_32(i_cal.hum[63:48]) * r_st[0].x;
        n_st[1].mh6 = r_st[0].x * sx8_32(i_cal.h6);
        n_st[1].mh3 = r_st[0].x * {24'b0, i_cal.hum[31:24]};

        n_st[2] = r_st[1];
        sa = ({16'b0, r_st[1].item.smp.adc_hum} << 14) - (sx16_32(i_cal.hum[47:32]) << 20)
             - r_st[1].mh5 + H_ROUND;
        n_st[2].ra = asr32(sa, 15);
        n_st[2].p1 = asr32(r_st[1].mh6, 10);
        n_st[2].p2 = asr32(r_st[1].mh3, 11) + H_BIAS_A;

        n_st[3]    = r_st[2];
        n_st[3].bm = r_st[2].p1 * r_st[2].p2;

        n_st[4]    = r_st[3];
        n_st[4].b2 = asr32(r_st[3].bm, 10) + H_BIAS_B;
        n_st[4].c  = sx16_32(i_cal.hum[23:8]) + H_BIAS_C;

        n_st[5]     = r_st[4];
        n_st[5].bm3 = r_st[4].b2 * r_st[4].c;

        n_st[6]   = r_st[5];
        n_st[6].v = r_st[5].ra * asr32(r_st[5].bm3, 14);

        n_st[7]    = r_st[6];
        sv = asr32(r_st[6].v, 15);
        n_st[7].ss = sv * sv;

        n_st[8]   = r_st[7];
        n_st[8].t = asr32(r_st[7].ss, 7) * {24'b0, i_cal.hum[7:0]};

        n_st[9] = r_st[8];
        vv = r_st[8].v - asr32(r_st[8].t, 4);
        if (vv[31]) begin
            vc = '0;
        end else if (vv > H_MAX) begin
            vc = H_MAX;
        end else begin
            vc = vv;
        end
        n_st[9].item.hum = vc[28:12];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[N-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st <= n_st;
        end
    end

    assign o_valid = r_vld[N-1];
    assign o_item  = r_st[N-1].item;
endmodule

>>> sv/esc_pres.sv
// Pressure stages up to the dividend and the divisor
module esc_pres (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  esc_pkg::t_item  i_item,
    input  esc_pkg::t_calib i_cal,
    output logic            o_valid,
    output esc_pkg::t_item  o_item
);
    import esc_pkg::*;

    localparam int N = 9;

    typedef struct packed {
        t_item       item;
        logic [63:0] d;
        t_pp         pp_sq;
        t_pp         pp_5;
        t_pp         pp_2;
        logic [63:0] sq;
        logic [63:0] d5;
        logic [63:0] d2;
        t_pp         pp_6;
        t_pp         pp_3;
        logic [63:0] s6;
        logic [63:0] s3;
        logic [63:0] q1;
        logic [63:0] q2;
        logic [63:0] e;
        logic [63:0] n0;
        t_pp         pp_c;
        t_pp         pp_n;
    } t_st;

    t_st          r_st [N];
    t_st          n_st [N];
    logic [N-1:0] r_vld;

    always_comb begin
        logic [20:0] pr;
        logic [63:0] den_full;
        n_st[0]      = '0;
        n_st[0].item = i_item;
        n_st[0].d    = {{32{i_item.fine[31]}}, i_item.fine} - P_FINE_OFS;

        n_st[1]       = r_st[0];
        n_st[1].pp_sq = mul_pp(r_st[0].d, r_st[0].d);
        n_st[1].pp_5  = mul_pp(r_st[0].d, sx16_64(i_cal.pb[15:0]));
        n_st[1].pp_2  = mul_pp(r_st[0].d, sx16_64(i_cal.pa[31:16]));

        n_st[2]    = r_st[1];
        n_st[2].sq = mul_sum(r_st[1].pp_sq);
        n_st[2].d5 = mul_sum(r_st[1].pp_5);
        n_st[2].d2 = mul_sum(r_st[1].pp_2);

        n_st[3]      = r_st[2];
        n_st[3].pp_6 = mul_pp(r_st[2].sq, sx16_64(i_cal.pb[31:16]));
        n_st[3].pp_3 = mul_pp(r_st[2].sq, sx16_64(i_cal.pa[47:32]));

        n_st[4]    = r_st[3];
        n_st[4].s6 = mul_sum(r_st[3].pp_6);
        n_st[4].s3 = mul_sum(r_st[3].pp_3);

        n_st[5]    = r_st[4];
        n_st[5].q2 = r_st[4].s6 + (r_st[4].d5 << 17) + (sx16_64(i_cal.pa[63:48]) << 35);
        n_st[5].q1 = asr64(r_st[4].s3, 8) + (r_st[4].d2 << 12);

        n_st[6]   = r_st[5];
        pr = P_ADC_BASE - {1'b0, r_st[5].item.smp.adc_press};
        n_st[6].e  = r_st[5].q1 + P_HALF;
        n_st[6].n0 = ({43'b0, pr} << 31) - r_st[5].q2;

        n_st[7]      = r_st[6];
        n_st[7].pp_c = mul_pp(r_st[6].e, {48'b0, i_cal.pa[15:0]});
        n_st[7].pp_n = mul_pp(r_st[6].n0, P_SCALE);

        n_st[8]          = r_st[7];
        den_full         = mul_sum(r_st[7].pp_c);
        n_st[8].item.num = mul_sum(r_st[7].pp_n);
        n_st[8].item.den = den_full[63:33];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[N-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st <= n_st;
        end
    end

    assign o_valid = r_vld[N-1];
    assign o_item  = r_st[N-1].item;
endmodule

>>> sv/esc_div.sv
// Pipelined signed 64 by 31 bit divider, one quotient bit per stage
module esc_div (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  esc_pkg::t_item i_item,
    output logic           o_valid,
    output esc_pkg::t_item o_item
);
    import esc_pkg::*;

    localparam int QW = 64;
    localparam int N  = QW + 1;

    typedef struct packed {
        t_item       item;
        logic [30:0] dm;
        logic [30:0] rem;
        logic [63:0] nq;
    } t_st;

    t_st          r_st [N];
    t_st          n_st [N];
    logic [N-1:0] r_vld;

    always_comb begin
        logic [31:0] tr;
        logic        ge;
        n_st[0]         = '0;
        n_st[0].item    = i_item;
        n_st[0].item.neg = i_item.num[63] ^ i_item.den[30];
        n_st[0].item.dz  = (i_item.den == '0);
        n_st[0].dm  = i_item.den[30] ? (31'd0 - i_item.den) : i_item.den;
        n_st[0].nq  = i_item.num[63] ? (64'd0 - i_item.num) : i_item.num;
        n_st[0].rem = '0;
        for (int k = 1; k < N; k++) begin
            n_st[k]     = r_st[k-1];
            tr          = {r_st[k-1].rem, r_st[k-1].nq[QW-1]};
            ge          = (tr >= {1'b0, r_st[k-1].dm});
            n_st[k].rem = ge ? 31'(tr - {1'b0, r_st[k-1].dm}) : tr[30:0];
            n_st[k].nq  = {r_st[k-1].nq[QW-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[N-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st <= n_st;
        end
    end

    always_comb begin
        o_item     = r_st[N-1].item;
        o_item.quo = r_st[N-1].nq;
    end

    assign o_valid = r_vld[N-1];
endmodule

>>> sv/esc_post.sv
// Pressure stages after the divider, with range limiting
module esc_post (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  esc_pkg::t_item  i_item,
    input  esc_pkg::t_calib i_cal,
    output logic            o_valid,
    output esc_pkg::t_item  o_item
);
    import esc_pkg::*;

    localparam int N = 8;

    typedef struct packed {
        t_item       item;
        logic [63:0] p;
        logic [63:0] t;
        t_pp         pp1;
        t_pp         pp2;
        logic [63:0] m1;
        logic [63:0] m2;
        t_pp         pp3;
        logic [63:0] q2;
        logic [63:0] m3;
        logic [63:0] s;
        logic [63:0] pf;
    } t_st;

    t_st          r_st [N];
    t_st          n_st [N];
    logic [N-1:0] r_vld;

    always_comb begin
        n_st[0]      = '0;
        n_st[0].item = i_item;
        n_st[0].p    = i_item.neg ? (64'd0 - i_item.quo) : i_item.quo;

        n_st[1]     = r_st[0];
        n_st[1].t   = asr64(r_st[0].p, 13);
        n_st[1].pp1 = mul_pp(sx16_64(i_cal.pc), asr64(r_st[0].p, 13));
        n_st[1].pp2 = mul_pp(sx16_64(i_cal.pb[63:48]), r_st[0].p);

        n_st[2]    = r_st[1];
        n_st[2].m1 = mul_sum(r_st[1].pp1);
        n_st[2].m2 = mul_sum(r_st[1].pp2);

        n_st[3]     = r_st[2];
        n_st[3].pp3 = mul_pp(r_st[2].m1, r_st[2].t);
        n_st[3].q2  = asr64(r_st[2].m2, 19);

        n_st[4]    = r_st[3];
        n_st[4].m3 = mul_sum(r_st[3].pp3);

        n_st[5]   = r_st[4];
        n_st[5].s = r_st[4].p + asr64(r_st[4].m3, 25) + r_st[4].q2;

        n_st[6]    = r_st[5];
        n_st[6].pf = asr64(r_st[5].s, 8) + (sx16_64(i_cal.pb[47:32]) << 4);

        n_st[7]                    = r_st[6];
        n_st[7].item.press_invalid = r_st[6].item.dz;
        if (r_st[6].item.dz || r_st[6].pf[63]) begin
            n_st[7].item.press = '0;
        end else if (|r_st[6].pf[62:32]) begin
            n_st[7].item.press = '1;
        end else begin
            n_st[7].item.press = r_st[6].pf[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[N-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st <= n_st;
        end
    end

    assign o_valid = r_vld[N-1];
    assign o_item  = r_st[N-1].item;
endmodule

>>> sv/env_sensor_compensation.sv
// Top level of the environmental sensor compensation pipeline
// Takes one sample per clock unless the output stalls; returns one result per sample, in
// order. Temperature (5 stages), humidity (10), pressure set-up (9), divider (65, one
// quotient bit a stage) and pressure finish (8) run as one stalling pipeline; the last
// stage is the output register. The six calibration registers reset to zero; the user must
// write them only while no transaction is in flight, which the block does not enforce.
module env_sensor_compensation (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [esc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [esc_pkg::CFG_W-1:0]         i_cfg_data,
    esc_stream_if.sink                        i_sample,
    esc_stream_if.source                      o_result
);
    import esc_pkg::*;

    t_calib r_cal;
    logic   w_en;
    t_item  w_in_item;
    logic   w_vld_t, w_vld_h, w_vld_p, w_vld_d, w_vld_o;
    t_item  w_item_t, w_item_h, w_item_p, w_item_d, w_item_o;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_TEMP_CALIB: r_cal.temp <= i_cfg_data[47:0];
                REG_PRESS_A:    r_cal.pa   <= i_cfg_data;
                REG_PRESS_B:    r_cal.pb   <= i_cfg_data;
                REG_PRESS_C:    r_cal.pc   <= i_cfg_data[15:0];
                REG_HUM:        r_cal.hum  <= i_cfg_data;
                REG_HUM_H6:     r_cal.h6   <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign w_en           = !w_vld_o || o_result.ready;
    assign i_sample.ready = w_en;

    always_comb begin
        w_in_item     = '0;
        w_in_item.smp = i_sample.data;
    end

    esc_temp u_temp (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(i_sample.valid), .i_item(w_in_item),
        .i_cal(r_cal), .o_valid(w_vld_t), .o_item(w_item_t)
    );

    esc_hum u_hum (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(w_vld_t), .i_item(w_item_t),
        .i_cal(r_cal), .o_valid(w_vld_h), .o_item(w_item_h)
    );

    esc_pres u_pres (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(w_vld_h), .i_item(w_item_h),
        .i_cal(r_cal), .o_valid(w_vld_p), .o_item(w_item_p)
    );

    esc_div u_div (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(w_vld_p), .i_item(w_item_p),
        .o_valid(w_vld_d), .o_item(w_item_d)
    );

    esc_post u_post (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(w_vld_d), .i_item(w_item_d),
        .i_cal(r_cal), .o_valid(w_vld_o), .o_item(w_item_o)
    );

    assign o_result.valid              = w_vld_o;
    assign o_result.data.temp_centi    = w_item_o.temp_centi;
    assign o_result.data.press_q24_8   = w_item_o.press;
    assign o_result.data.press_invalid = w_item_o.press_invalid;
    assign o_result.data.hum_q22_10    = w_item_o.hum;
endmodule

>>> sv/esc_checker.sv
// Port-level checks of the sensor compensation block and their binding
`include "env_sensor_compensation_assert.svh"

module esc_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input esc_pkg::t_result i_out_data
);
    `ESC_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid, "result dropped while stalled")
    `ESC_ASSERT(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> $stable(i_out_data), "result changed while stalled")
    `ESC_ASSERT(a_hum_range, i_clk, i_rst_n, i_out_valid |-> i_out_data.hum_q22_10 <= 17'd102400, "humidity above clamp")
    `ESC_ASSERT(a_press_invalid, i_clk, i_rst_n, i_out_valid && i_out_data.press_invalid |-> i_out_data.press_q24_8 == 32'd0, "invalid pressure not zero")
    `ESC_ASSERT_ALWAYS(a_reset_clear, i_clk, !i_rst_n |=> !i_out_valid, "result valid after reset")
endmodule

bind env_sensor_compensation esc_checker u_esc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out_data  (o_result.data)
);
